[hdl/tcrs_pkg.sv]
`timescale 1ns / 1ps

package tcrs_pkg;

    localparam int NUM_REGS    = 6;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PIX_W       = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int DIFF_W      = CFG_W + 1;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_AX = 3'd0;
    localparam t_reg_idx REG_AY = 3'd1;
    localparam t_reg_idx REG_BX = 3'd2;
    localparam t_reg_idx REG_BY = 3'd3;
    localparam t_reg_idx REG_CX = 3'd4;
    localparam t_reg_idx REG_CY = 3'd5;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_cfg_regs;

    // element order: cy, cx, by, bx, ay, ax
    localparam t_cfg_regs CFG_RESET = '{16'd4800, 16'd4800, 16'd4800,
                                         16'd1600, 16'd1600, 16'd3200};

    typedef enum logic [1:0] {
        ORIENT_DEGEN = 2'd0,
        ORIENT_POS   = 2'd1,
        ORIENT_NEG   = 2'd2
    } t_orient;

    typedef logic [1:0] t_settle;

    localparam t_settle SETTLE_CYCLES = 2'd3;

endpackage

[hdl/tcrs_setup.sv]
`timescale 1ns / 1ps

module tcrs_setup #(
    parameter int FRACTION_BITS = 4,
    parameter int EDGE_W        = 37
) (
    input  logic                     i_clk,
    input  tcrs_pkg::t_cfg_regs      i_regs,
    output logic signed [EDGE_W-1:0] o_edge_start [3],
    output logic signed [EDGE_W-1:0] o_step_col [3],
    output logic signed [EDGE_W-1:0] o_step_row [3],
    output tcrs_pkg::t_orient        o_orient
);

    import tcrs_pkg::*;

    logic        [CFG_W-1:0]  ax, ay, bx, by, cx, cy;
    logic        [PROD_W-1:0] r_prod_pos [3];
    logic        [PROD_W-1:0] r_prod_neg [3];
    logic signed [DIFF_W-1:0] r_dcol [3];
    logic signed [DIFF_W-1:0] r_drow [3];
    logic signed [PROD_W:0]   edge_diff [3];
    logic signed [EDGE_W-1:0] r_edge [3];
    logic signed [EDGE_W-1:0] r_scol [3];
    logic signed [EDGE_W-1:0] r_srow [3];
    logic signed [EDGE_W-1:0] area2;
    t_orient                  r_orient;
    t_orient                  n_orient;

    assign ax = i_regs[REG_AX];
    assign ay = i_regs[REG_AY];
    assign bx = i_regs[REG_BX];
    assign by = i_regs[REG_BY];
    assign cx = i_regs[REG_CX];
    assign cy = i_regs[REG_CY];

    // stage 1: cross products and vertex differences
    always_ff @(posedge i_clk) begin
        r_prod_pos[0] <= bx * cy;
        r_prod_neg[0] <= cx * by;
        r_prod_pos[1] <= cx * ay;
        r_prod_neg[1] <= ax * cy;
        r_prod_pos[2] <= ax * by;
        r_prod_neg[2] <= bx * ay;
        r_dcol[0]     <= $signed({1'b0, by}) - $signed({1'b0, cy});
        r_dcol[1]     <= $signed({1'b0, cy}) - $signed({1'b0, ay});
        r_dcol[2]     <= $signed({1'b0, ay}) - $signed({1'b0, by});
        r_drow[0]     <= $signed({1'b0, cx}) - $signed({1'b0, bx});
        r_drow[1]     <= $signed({1'b0, ax}) - $signed({1'b0, cx});
        r_drow[2]     <= $signed({1'b0, bx}) - $signed({1'b0, ax});
    end

    // stage 2: edge values at the origin and per-pixel steps
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            edge_diff[k] = $signed({1'b0, r_prod_pos[k]}) - $signed({1'b0, r_prod_neg[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_edge[k] <= EDGE_W'(edge_diff[k]);
            r_scol[k] <= EDGE_W'(r_dcol[k]) <<< FRACTION_BITS;
            r_srow[k] <= EDGE_W'(r_drow[k]) <<< FRACTION_BITS;
        end
    end

    // stage 3: sign of twice the area
    assign area2 = r_edge[0] + r_edge[1] + r_edge[2];

    always_comb begin
        if (area2 > 0) begin
            n_orient = ORIENT_POS;
        end else if (area2 < 0) begin
            n_orient = ORIENT_NEG;
        end else begin
            n_orient = ORIENT_DEGEN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_orient <= n_orient;
    end

    assign o_edge_start = r_edge;
    assign o_step_col   = r_scol;
    assign o_step_row   = r_srow;
    assign o_orient     = r_orient;

endmodule

[hdl/triangle_coverage_raster_scan.sv]
`timescale 1ns / 1ps

// Walks an IMAGE_WIDTH x IMAGE_HEIGHT image in raster order, one pixel per input transfer, and
// reports whether each integer pixel position lies inside the triangle given by the six vertex
// registers (unsigned fixed point, FRACTION_BITS fraction bits), edges included; a triangle of
// zero area covers nothing. Input tdata bit 0 is restart: 1 begins a frame at pixel (0,0), 0
// advances one pixel (a frame also begins when none is active). The vertices are sampled at
// frame start, so register writes take effect at the next frame. One pixel is taken and one
// result produced per clock; a new pixel enters in the cycle the previous result leaves the
// output register, and a stalled output holds off the input. After reset and after every
// register write the input is held off while the setup multipliers and adders recompute the
// edge equations.
module triangle_coverage_raster_scan #(
    parameter int IMAGE_WIDTH   = 400,
    parameter int IMAGE_HEIGHT  = 400,
    parameter int FRACTION_BITS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcrs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcrs_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tcrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // restart
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tcrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // pixel_x, pixel_y, covered
    output logic                             m_axis_tlast   // frame_end
);

    import tcrs_pkg::*;

    localparam int EDGE_W = FRACTION_BITS + 33;
    localparam int CW     = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int RW     = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;

    localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(IMAGE_HEIGHT - 1);

    t_cfg_regs                r_regs;
    t_settle                  r_settle;
    logic signed [EDGE_W-1:0] setup_edge [3];
    logic signed [EDGE_W-1:0] setup_scol [3];
    logic signed [EDGE_W-1:0] setup_srow [3];
    t_orient                  setup_orient;

    logic                     r_frame_active, n_frame_active;
    logic [CW-1:0]            r_col, n_col;
    logic [RW-1:0]            r_row, n_row;
    logic signed [EDGE_W-1:0] r_cur [3];
    logic signed [EDGE_W-1:0] n_cur [3];
    logic signed [EDGE_W-1:0] r_row_start [3];
    logic signed [EDGE_W-1:0] n_row_start [3];
    logic signed [EDGE_W-1:0] r_scol [3];
    logic signed [EDGE_W-1:0] n_scol [3];
    logic signed [EDGE_W-1:0] r_srow [3];
    logic signed [EDGE_W-1:0] n_srow [3];
    t_orient                  r_orient, n_orient;

    logic                     r_out_valid;
    logic [PIX_W-1:0]         r_out_x, n_out_x;
    logic [PIX_W-1:0]         r_out_y, n_out_y;
    logic                     r_out_cov, n_out_cov;
    logic                     r_out_last, n_out_last;

    logic                     in_xfer;
    logic                     start;
    logic                     wrap;
    logic [CW+PIX_W-1:0]      col_ext;
    logic [RW+PIX_W-1:0]      row_ext;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_regs[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // hold off input until the setup pipeline has settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else if (i_cfg_we) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    tcrs_setup #(
        .FRACTION_BITS (FRACTION_BITS),
        .EDGE_W        (EDGE_W)
    ) u_setup (
        .i_clk        (i_clk),
        .i_regs       (r_regs),
        .o_edge_start (setup_edge),
        .o_step_col   (setup_scol),
        .o_step_row   (setup_srow),
        .o_orient     (setup_orient)
    );

    assign s_axis_tready = (r_settle == '0) && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tdata[0] || !r_frame_active;
    assign wrap          = (r_col == COL_LAST);

    // scan state
    always_comb begin
        n_col          = r_col;
        n_row          = r_row;
        n_cur          = r_cur;
        n_row_start    = r_row_start;
        n_scol         = r_scol;
        n_srow         = r_srow;
        n_orient       = r_orient;
        n_frame_active = r_frame_active;
        if (in_xfer) begin
            if (start) begin
                n_col       = '0;
                n_row       = '0;
                n_cur       = setup_edge;
                n_row_start = setup_edge;
                n_scol      = setup_scol;
                n_srow      = setup_srow;
                n_orient    = setup_orient;
            end else if (wrap) begin
                n_col = '0;
                n_row = r_row + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    n_row_start[k] = r_row_start[k] + r_srow[k];
                    n_cur[k]       = r_row_start[k] + r_srow[k];
                end
            end else begin
                n_col = r_col + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    n_cur[k] = r_cur[k] + r_scol[k];
                end
            end
            n_frame_active = !((n_col == COL_LAST) && (n_row == ROW_LAST));
        end
    end

    // result
    assign col_ext = {{PIX_W{1'b0}}, n_col};
    assign row_ext = {{PIX_W{1'b0}}, n_row};

    always_comb begin
        n_out_x    = col_ext[PIX_W-1:0];
        n_out_y    = row_ext[PIX_W-1:0];
        n_out_last = (n_col == COL_LAST) && (n_row == ROW_LAST);
        case (n_orient)
            ORIENT_POS: begin
                n_out_cov = !n_cur[0][EDGE_W-1] && !n_cur[1][EDGE_W-1]
                            && !n_cur[2][EDGE_W-1];
            end
            ORIENT_NEG: begin
                n_out_cov = (n_cur[0][EDGE_W-1] || (n_cur[0] == '0))
                            && (n_cur[1][EDGE_W-1] || (n_cur[1] == '0))
                            && (n_cur[2][EDGE_W-1] || (n_cur[2] == '0));
            end
            default: begin
                n_out_cov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_orient       <= ORIENT_DEGEN;
        end else begin
            r_frame_active <= n_frame_active;
            r_col          <= n_col;
            r_row          <= n_row;
            r_orient       <= n_orient;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_row_start <= n_row_start;
        r_scol      <= n_scol;
        r_srow      <= n_srow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_cov  <= n_out_cov;
            r_out_last <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * PIX_W - 1){1'b0}}, r_out_cov, r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input accepted right after a register write");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> (r_col <= COL_LAST))
        else $error("column counter past image width");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_frame_active)
        else $error("frame still active after its last pixel");

    a_degen_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_orient == ORIENT_DEGEN)) |-> !r_out_cov)
        else $error("zero-area triangle reported coverage");

    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tdata[0]) |=> ((r_col == '0) && (r_row == '0)))
        else $error("restart did not return to pixel zero");

endmodule
